// File: hdl/ppi_pkg.sv
// Shared types and constants for the mode 0 parallel port interface.
package ppi_pkg;

    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;

    localparam logic [1:0] SEL_PORT_A = 2'd0;
    localparam logic [1:0] SEL_PORT_B = 2'd1;
    localparam logic [1:0] SEL_PORT_C = 2'd2;
    localparam logic [1:0] SEL_CTRL   = 2'd3;

    localparam logic [7:0] RD_IDLE    = 8'hFF;
    localparam logic [7:0] RD_WRITE   = 8'h00;

    typedef struct packed {
        logic       mode;
        logic [1:0] port_select;
        logic [7:0] write_data;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } t_req;

    // Direction flags, 1 = input; packs as bit3 A, bit2 C upper, bit1 B, bit0 C lower.
    typedef struct packed {
        logic a;
        logic c_high;
        logic b;
        logic c_low;
    } t_dir;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic [7:0] drive_c;
        logic [3:0] direction_bits;
    } t_rsp;

endpackage

// File: hdl/ppi_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface ppi_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/ppi_regs.sv
// Port latches, direction flags and the per-item update and read logic.
module ppi_regs
    import ppi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [7:0] r_a;
    logic [7:0] r_b;
    logic [7:0] r_c;
    t_dir       r_dir;
    logic [7:0] n_a;
    logic [7:0] n_b;
    logic [7:0] n_c;
    t_dir       n_dir;
    logic [7:0] rd;

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_c   = r_c;
        n_dir = r_dir;
        rd    = RD_IDLE;
        if (i_req.mode == MODE_WRITE) begin
            rd = RD_WRITE;
            case (i_req.port_select)
                SEL_PORT_A: begin
                    if (!r_dir.a) n_a = i_req.write_data;
                end
                SEL_PORT_B: begin
                    if (!r_dir.b) n_b = i_req.write_data;
                end
                SEL_PORT_C: begin
                    if (!r_dir.c_low)  n_c[3:0] = i_req.write_data[3:0];
                    if (!r_dir.c_high) n_c[7:4] = i_req.write_data[7:4];
                end
                default: begin
                    if (i_req.write_data[7]) begin
                        n_dir.a      = i_req.write_data[4];
                        n_dir.c_high = i_req.write_data[3];
                        n_dir.b      = i_req.write_data[1];
                        n_dir.c_low  = i_req.write_data[0];
                    end else begin
                        n_c[i_req.write_data[3:1]] = i_req.write_data[0];
                    end
                end
            endcase
        end else begin
            case (i_req.port_select)
                SEL_PORT_A: begin
                    if (r_dir.a) begin
                        n_a = i_req.pins_a;
                        rd  = i_req.pins_a;
                    end
                end
                SEL_PORT_B: begin
                    if (r_dir.b) begin
                        n_b = i_req.pins_b;
                        rd  = i_req.pins_b;
                    end
                end
                SEL_PORT_C: begin
                    // partner's port C is nibble-swapped
                    if (r_dir.c_low)  n_c[3:0] = i_req.pins_c[7:4];
                    if (r_dir.c_high) n_c[7:4] = i_req.pins_c[3:0];
                    if (r_dir.c_low || r_dir.c_high) rd = n_c;
                end
                default: rd = RD_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= '0;
            r_dir <= '1;
        end else if (i_en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_c   <= n_c;
            r_dir <= n_dir;
        end
    end

    assign o_rsp = '{read_data: rd, drive_a: n_a, drive_b: n_b, drive_c: n_c,
                     direction_bits: n_dir};

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_a) && $stable(r_b) && $stable(r_c) && $stable(r_dir)))
        else $error("state changed without an item");

    a_dir_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.mode == MODE_WRITE && i_req.port_select == SEL_CTRL
         && i_req.write_data[7])
        |=> (r_dir == {$past(i_req.write_data[4]), $past(i_req.write_data[3]),
                       $past(i_req.write_data[1]), $past(i_req.write_data[0])}))
        else $error("direction load mismatch");

    a_read_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.mode == MODE_READ && i_req.port_select == SEL_PORT_A && r_dir.a)
        |=> (r_a == $past(i_req.pins_a)))
        else $error("port A sample not latched");

    a_write_b_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.mode == MODE_WRITE && i_req.port_select == SEL_PORT_B && r_dir.b)
        |=> $stable(r_b))
        else $error("write to input port B changed its latch");
`endif

endmodule

// File: hdl/parallel_port_interface_mode0_core.sv
// Top level of the mode 0 three-port parallel interface.
//
// i_req carries one bus access per item: mode (read/write), port_select
// (A, B, C, control), write_data and the partner pin values. o_rsp carries
// one result per item: read_data and the latch and direction values after
// the access. Both channels are valid/ready; an item moves when both are high.
// An accepted item is registered in the input register, then applied to
// the port state, and its result is loaded into the output register, from
// which it is offered on o_rsp.
// Throughput is one item per cycle while the receiver does not stall; the
// state update is a single layer of selection logic between the input
// register and the state registers.
// Reset clears all latches to zero and sets every port direction to input;
// both stages come out of reset empty.
// When the receiver stalls the result is held in the output register, one
// more item waits in the input register, and i_req.ready falls until
// o_rsp.ready returns.
module parallel_port_interface_mode0_core
    import ppi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppi_stream_if.sink   i_req,
    ppi_stream_if.source o_rsp
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic advance;
    t_rsp rsp;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    ppi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_in),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule
